// File: hdl/ejs_pkg.sv
// ----------------------------------------------------------------------------
// EUC-JP segmenter package
// Shared types, byte-class constants and lead/trail classification helpers.
// ----------------------------------------------------------------------------
package ejs_pkg;

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD_SS2    = 8'h8E;
   localparam logic [7:0] LEAD_SS3    = 8'h8F;
   localparam logic [7:0] TRAIL_MIN   = 8'hA1;
   localparam logic [7:0] TRAIL_MAX   = 8'hFE;

   // Number of bytes a lead byte asks for; zero marks a byte that cannot lead.
   localparam logic [1:0] NEED_BAD    = 2'd0;
   localparam logic [1:0] NEED_ONE    = 2'd1;
   localparam logic [1:0] NEED_TWO    = 2'd2;
   localparam logic [1:0] NEED_THREE  = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   // Decision of the segment decoder on the front of the byte buffer.
   typedef struct packed {
      logic        emit;
      logic        ok;
      logic [1:0]  len;
      logic [23:0] value;
   } seg_dec_type;

   // One result beat.
   typedef struct packed {
      logic        ok;
      logic [1:0]  len;
      logic [23:0] value;
      logic        run_end;
   } rsp_beat_type;

   function automatic logic trail_ok(input logic [7:0] c);
      return (c >= TRAIL_MIN) && (c <= TRAIL_MAX);
   endfunction

   function automatic logic [1:0] seg_need(input logic [7:0] c);
      logic [1:0] n;
      if (c < ASCII_LIMIT) begin
         n = NEED_ONE;
      end else if (c == LEAD_SS2 || trail_ok(c)) begin
         n = NEED_TWO;
      end else if (c == LEAD_SS3) begin
         n = NEED_THREE;
      end else begin
         n = NEED_BAD;
      end
      return n;
   endfunction

endpackage

// File: hdl/ejs_seg_unit.sv
// ----------------------------------------------------------------------------
// EUC-JP segment decoder
// Classifies the segment at the front of a buffer of up to three bytes.
// ----------------------------------------------------------------------------
module ejs_seg_unit (
   input  logic [7:0]          byte0,
   input  logic [7:0]          byte1,
   input  logic [7:0]          byte2,
   input  logic [1:0]          count,
   input  logic                final_seen,
   output ejs_pkg::seg_dec_type dec
);

   logic [1:0] need;
   logic [1:0] lim;
   logic       bad_trail;
   logic [1:0] seg_len;

   always_comb begin
      need      = ejs_pkg::seg_need(byte0);
      lim       = (count < need) ? count : need;
      bad_trail = ((lim >= 2'd2) && !ejs_pkg::trail_ok(byte1)) ||
                  ((lim == 2'd3) && !ejs_pkg::trail_ok(byte2));
      dec.emit  = 1'b0;
      dec.ok    = 1'b0;
      seg_len   = 2'd1;

      if (count == 2'd0) begin
         dec.emit = 1'b0;
      end else if (need == ejs_pkg::NEED_BAD) begin
         dec.emit = 1'b1;
      end else if (need == ejs_pkg::NEED_ONE) begin
         dec.emit = 1'b1;
         dec.ok   = 1'b1;
      end else if (count < need && final_seen) begin
         // A short tail at the end of the string goes out whole.
         dec.emit = 1'b1;
         seg_len  = count;
      end else if (bad_trail) begin
         dec.emit = 1'b1;
      end else if (count < need) begin
         dec.emit = 1'b0;
      end else begin
         dec.emit = 1'b1;
         dec.ok   = 1'b1;
         seg_len  = need;
      end

      dec.len = seg_len;
      case (seg_len)
         2'd2:    dec.value = {8'h00, byte0, byte1};
         2'd3:    dec.value = {byte0, byte1, byte2};
         default: dec.value = {16'h0000, byte0};
      endcase
   end

endmodule

// File: hdl/ejs_out_reg.sv
// ----------------------------------------------------------------------------
// EUC-JP segmenter output register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module ejs_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ejs_pkg::rsp_beat_type beat,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_char_ok,
   output logic [1:0]            rsp_char_length,
   output logic [23:0]           rsp_char_value,
   output logic                  rsp_run_end
);

   logic                  valid_ff;
   logic                  valid_in;
   ejs_pkg::rsp_beat_type beat_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = push ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         beat_ff <= beat;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_char_ok     = beat_ff.ok;
   assign rsp_char_length = beat_ff.len;
   assign rsp_char_value  = beat_ff.value;
   assign rsp_run_end     = beat_ff.run_end;

endmodule

// File: hdl/eucjp_char_segmenter_core.sv
// ----------------------------------------------------------------------------
// EUC-JP character segmenter core
// Cuts a byte stream into EUC-JP characters, invalid bytes and short tails.
// ----------------------------------------------------------------------------
// Sequence: a found segment is held pending until a further decoder pass pushes
//   it into the output register. Each byte is loaded in S_IDLE, then gets one
//   decoder pass per segment found and one closing pass; no new byte is taken
//   before the closing pass, and a full output register holds the passes.
// Reset: synchronous, active high; clears the hold, the sequencer and the
//   output valid. Held byte contents are not cleared.
// ----------------------------------------------------------------------------
module eucjp_char_segmenter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_char_ok,
   output logic [1:0]  rsp_char_length,
   output logic [23:0] rsp_char_value,
   output logic        rsp_run_end
);

   // Sequencer state. In S_IDLE the byte buffer holds the unfinished
   // character (count 0 to 2); in S_SCAN it holds up to three bytes that
   // the decoder walks through, one segment per pass.
   ejs_pkg::state_type state_ff, state_in;

   // Byte buffer, front byte first. The bytes are payload and are not reset.
   logic [7:0] byte0_ff, byte0_in;
   logic [7:0] byte1_ff, byte1_in;
   logic [7:0] byte2_ff, byte2_in;
   logic [1:0] count_ff, count_in;
   logic       fin_ff,   fin_in;

   // One segment is kept pending so that run_end can be set on it once
   // the next pass shows whether this byte gives any further segment.
   logic                 pend_vld_ff, pend_vld_in;
   ejs_pkg::seg_dec_type pend_ff,     pend_in;

   ejs_pkg::seg_dec_type  dec;
   ejs_pkg::rsp_beat_type beat;
   logic                  out_free;
   logic                  out_push;
   logic                  accept;
   logic                  advance;

   ejs_seg_unit u_seg (
      .byte0      (byte0_ff),
      .byte1      (byte1_ff),
      .byte2      (byte2_ff),
      .count      (count_ff),
      .final_seen (fin_ff),
      .dec        (dec)
   );

   assign req_ready = (state_ff == ejs_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;

   // A decoder pass may proceed when there is no pending segment, or when
   // the output register can take the pending one this cycle.
   assign advance  = (state_ff == ejs_pkg::S_SCAN) && (!pend_vld_ff || out_free);
   assign out_push = advance && pend_vld_ff;

   // The pending beat closes the run when the decoder finds nothing more.
   assign beat.ok      = pend_ff.ok;
   assign beat.len     = pend_ff.len;
   assign beat.value   = pend_ff.value;
   assign beat.run_end = !dec.emit;

   always_comb begin
      state_in    = state_ff;
      byte0_in    = byte0_ff;
      byte1_in    = byte1_ff;
      byte2_in    = byte2_ff;
      count_in    = count_ff;
      fin_in      = fin_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;

      case (state_ff)
         ejs_pkg::S_IDLE: begin
            if (accept) begin
               // The new byte goes in behind the held ones.
               case (count_ff)
                  2'd0:    byte0_in = req_data_byte;
                  2'd1:    byte1_in = req_data_byte;
                  default: byte2_in = req_data_byte;
               endcase
               count_in = count_ff + 2'd1;
               fin_in   = req_final_byte;
               state_in = ejs_pkg::S_SCAN;
            end
         end
         ejs_pkg::S_SCAN: begin
            if (advance) begin
               if (dec.emit) begin
                  // Take the segment off the front of the buffer.
                  pend_vld_in = 1'b1;
                  pend_in     = dec;
                  count_in    = count_ff - dec.len;
                  case (dec.len)
                     2'd1: begin
                        byte0_in = byte1_ff;
                        byte1_in = byte2_ff;
                     end
                     2'd2: begin
                        byte0_in = byte2_ff;
                     end
                     default: begin
                        byte0_in = byte0_ff;
                     end
                  endcase
               end else begin
                  // Nothing more for this byte: whatever is left stays held.
                  pend_vld_in = 1'b0;
                  state_in    = ejs_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in    = ejs_pkg::S_IDLE;
            pend_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ejs_pkg::S_IDLE;
         count_ff    <= 2'd0;
         fin_ff      <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         fin_ff      <= fin_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
      byte2_ff <= byte2_in;
      pend_ff  <= pend_in;
   end

   ejs_out_reg u_out (
      .clock           (clock),
      .reset           (reset),
      .push            (out_push),
      .beat            (beat),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_ok     (rsp_char_ok),
      .rsp_char_length (rsp_char_length),
      .rsp_char_value  (rsp_char_value),
      .rsp_run_end     (rsp_run_end)
   );

   // The hold between bytes never exceeds two bytes.
   a_hold_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ejs_pkg::S_IDLE) |-> (count_ff <= 2'd2))
      else $error("hold count exceeds two bytes");

   // The final byte of a string always drains the buffer completely.
   a_final_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ejs_pkg::S_IDLE && fin_ff) |-> (count_ff == 2'd0))
      else $error("bytes left held after the final byte");

   // No pending segment survives into the idle state.
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ejs_pkg::S_IDLE) |-> !pend_vld_ff)
      else $error("pending segment lost on return to idle");

   // A new result beat only comes from a decoder pass.
   a_beat_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ejs_pkg::S_SCAN))
      else $error("result beat raised outside a scan");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// EUC-JP character segmenter testbench
// Feeds byte strings through eucjp_char_segmenter_core and checks every result
// beat against a self-contained segmentation predictor. A short table covers
// the byte-class extremes, bad leads, bad trails and truncated tails. Random
// text of mostly well-formed characters follows, mixed with noise and broken
// sequences, under three idling mixes and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 7;
   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 80;
   localparam int TAIL_CYCLES  = 16;
   localparam int N_DIRECTED   = 26;

   // One row of the directed table. Where known is set, the typed result is
   // the single beat the byte must give; other rows go to the predictor.
   typedef struct packed {
      logic [7:0]  data;
      logic        fin;
      logic        known;
      logic        ok;
      logic [1:0]  len;
      logic [23:0] value;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_final_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_char_ok;
   logic [1:0]  rsp_char_length;
   logic [23:0] rsp_char_value;
   logic        rsp_run_end;

   // Predictor state: bytes of a character still waiting for its trail.
   logic [7:0]            held_lead [0:1];
   int unsigned           held_total;
   ejs_pkg::rsp_beat_type scan_out [0:2];
   int unsigned           scan_count;

   ejs_pkg::rsp_beat_type expected_segments [$];
   ejs_pkg::rsp_beat_type seen_beat;
   ejs_pkg::rsp_beat_type due_beat;

   // Typed expectation that travels with the byte on offer.
   logic                  row_known;
   ejs_pkg::rsp_beat_type row_beat;

   int unsigned tx_idle_pct;
   int unsigned rx_idle_pct;
   bit          want_long_hold;
   bit          long_hold_done;

   int unsigned error_count;
   int unsigned bytes_accepted;
   int unsigned strings_ended;
   int unsigned segments_checked;
   int unsigned quiet_cycles;

   stim_row_type directed_rows [0:N_DIRECTED-1] = '{
      '{8'h00, 1'b1, 1'b1, 1'b1, 2'd1, 24'h000000},
      '{8'h7F, 1'b0, 1'b1, 1'b1, 2'd1, 24'h00007F},
      '{8'h80, 1'b0, 1'b1, 1'b0, 2'd1, 24'h000080},
      '{8'hFF, 1'b0, 1'b1, 1'b0, 2'd1, 24'h0000FF},
      '{8'hA0, 1'b0, 1'b1, 1'b0, 2'd1, 24'h0000A0},
      '{8'hA1, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hFE, 1'b0, 1'b1, 1'b1, 2'd2, 24'h00A1FE},
      '{8'h8E, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hA1, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'h8F, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hA1, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hFE, 1'b0, 1'b1, 1'b1, 2'd3, 24'h8FA1FE},
      '{8'hB0, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'h41, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'h8F, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hA1, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'h20, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'h8F, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hA1, 1'b1, 1'b1, 1'b0, 2'd2, 24'h008FA1},
      '{8'hC0, 1'b1, 1'b1, 1'b0, 2'd1, 24'h0000C0},
      '{8'h8F, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'h41, 1'b1, 1'b1, 1'b0, 2'd2, 24'h008F41},
      '{8'h8E, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'h8D, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hA5, 1'b0, 1'b0, 1'b0, 2'd0, 24'h000000},
      '{8'hA5, 1'b1, 1'b0, 1'b0, 2'd0, 24'h000000}
   };

   eucjp_char_segmenter_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_ok     (rsp_char_ok),
      .rsp_char_length (rsp_char_length),
      .rsp_char_value  (rsp_char_value),
      .rsp_run_end     (rsp_run_end)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Segmentation predictor
   // ------------------------------------------------------------------------

   function automatic logic is_trail_byte(input logic [7:0] c);
      return (c >= ejs_pkg::TRAIL_MIN) && (c <= ejs_pkg::TRAIL_MAX);
   endfunction

   // Bytes a character needs when c stands at its front; zero when c can
   // never begin a character.
   function automatic int unsigned lead_span(input logic [7:0] c);
      int unsigned span;
      if (c < ejs_pkg::ASCII_LIMIT) begin
         span = 1;
      end else if (c == ejs_pkg::LEAD_SS3) begin
         span = 3;
      end else if (c == ejs_pkg::LEAD_SS2 || is_trail_byte(c)) begin
         span = 2;
      end else begin
         span = 0;
      end
      return span;
   endfunction

   // Adds one segment to the beats caused by the current byte, packing its
   // bytes big-endian.
   task automatic add_segment(input logic ok, input logic [7:0] seg [0:2],
                              input int unsigned from, input int unsigned len);
      logic [23:0] packed_value;
      packed_value = '0;
      for (int unsigned j = 0; j < len; j++) begin
         packed_value = {packed_value[15:0], seg[from + j]};
      end
      scan_out[scan_count] = '{ok: ok, len: len[1:0], value: packed_value, run_end: 1'b0};
      scan_count++;
   endtask

   // Rescans the held bytes with the new one from the front, fills scan_out
   // with the beats the byte causes and leaves the unfinished remainder held.
   task automatic segment_byte(input logic [7:0] b, input logic fin);
      logic [7:0]  seg [0:2];
      int unsigned n;
      int unsigned pos;
      int unsigned span;
      int unsigned avail;
      int unsigned lim;
      bit          bad;
      n = 0;
      pos = 0;
      scan_count = 0;
      seg = '{default: 8'h00};
      for (int unsigned i = 0; i < held_total; i++) begin
         seg[n] = held_lead[i];
         n++;
      end
      seg[n] = b;
      n++;
      while (pos < n) begin
         span  = lead_span(seg[pos]);
         avail = n - pos;
         if (span == 0) begin
            add_segment(1'b0, seg, pos, 1);
            pos++;
         end else if (span == 1) begin
            add_segment(1'b1, seg, pos, 1);
            pos++;
         end else if (avail < span && fin) begin
            // A short tail at the end of the string goes out whole, even if
            // one of its trail bytes is bad.
            add_segment(1'b0, seg, pos, avail);
            pos = n;
         end else begin
            lim = (avail < span) ? avail : span;
            bad = 1'b0;
            for (int unsigned j = 1; j < lim; j++) begin
               if (!is_trail_byte(seg[pos + j])) begin
                  bad = 1'b1;
               end
            end
            if (bad) begin
               // Only the lead is rejected; what follows is scanned again.
               add_segment(1'b0, seg, pos, 1);
               pos++;
            end else if (avail < span) begin
               break;
            end else begin
               add_segment(1'b1, seg, pos, span);
               pos += span;
            end
         end
      end
      held_total = 0;
      while (pos < n && held_total < 2) begin
         held_lead[held_total] = seg[pos];
         held_total++;
         pos++;
      end
      if (scan_count > 0) begin
         scan_out[scan_count - 1].run_end = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: both channels are sampled at the rising edge, the input first
   // so that expectations are in place before any result could be compared.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         held_total   = 0;
         quiet_cycles = 0;
      end else begin
         if (req_valid && req_ready) begin
            segment_byte(req_data_byte, req_final_byte);
            if (row_known) begin
               expected_segments.push_back(row_beat);
            end else begin
               for (int unsigned i = 0; i < scan_count; i++) begin
                  expected_segments.push_back(scan_out[i]);
               end
            end
            bytes_accepted++;
            if (req_final_byte) begin
               strings_ended++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            seen_beat = '{ok: rsp_char_ok, len: rsp_char_length,
                          value: rsp_char_value, run_end: rsp_run_end};
            if (expected_segments.size() == 0) begin
               $display("%0t: unexpected beat ok=%0b len=%0d value=%06h run_end=%0b",
                        $time, seen_beat.ok, seen_beat.len, seen_beat.value,
                        seen_beat.run_end);
               error_count++;
            end else begin
               due_beat = expected_segments.pop_front();
               segments_checked++;
               if (seen_beat.ok !== due_beat.ok || seen_beat.len !== due_beat.len ||
                   seen_beat.value !== due_beat.value ||
                   seen_beat.run_end !== due_beat.run_end) begin
                  $display("%0t: mismatch, expected ok=%0b len=%0d value=%06h run_end=%0b",
                           $time, due_beat.ok, due_beat.len, due_beat.value,
                           due_beat.run_end);
                  $display("%0t:           actual ok=%0b len=%0d value=%06h run_end=%0b",
                           $time, seen_beat.ok, seen_beat.len, seen_beat.value,
                           seen_beat.run_end);
                  error_count++;
               end
            end
         end
         // The watchdog only counts cycles in which neither channel moved a
         // beat, so long legal stalls reset it as soon as traffic resumes.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, expected_segments.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side: random back-pressure, plus one long hold-off at the start
   // of the final phase while the sender keeps offering bytes, so that the
   // block fills up and has to stall its input.
   // ------------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (want_long_hold && !long_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Byte side
   // ------------------------------------------------------------------------

   // Offers one byte from a falling edge and returns at the falling edge
   // after it was taken. Idle cycles drop valid before the byte goes up, so
   // that a beat once offered is never withdrawn.
   task automatic offer_byte(input logic [7:0] b, input logic fin, input logic known,
                             input ejs_pkg::rsp_beat_type typed);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      row_known = known;
      row_beat  = typed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Holds the input back until every result owed so far has come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_segments.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_trail();
      return 8'($urandom_range(ejs_pkg::TRAIL_MIN, ejs_pkg::TRAIL_MAX));
   endfunction

   function automatic logic [7:0] pick_non_trail();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      if (is_trail_byte(c)) begin
         c = c - ejs_pkg::TRAIL_MIN;
      end
      return c;
   endfunction

   function automatic logic [7:0] pick_multibyte_lead();
      logic [7:0] c;
      case ($urandom_range(5))
         0:       c = ejs_pkg::LEAD_SS2;
         1:       c = ejs_pkg::LEAD_SS3;
         default: c = pick_trail();
      endcase
      return c;
   endfunction

   // Random text: mostly complete characters of all three lengths, with
   // noise bytes, bad trails and strings cut short mixed in. Every string cut
   // short closes, and about one other character in ten closes its string.
   task automatic send_random_text(input int unsigned count);
      logic [7:0]  chunk [0:2];
      int unsigned sent;
      int unsigned pick;
      int unsigned span;
      int unsigned cut;
      logic        closes;
      sent = 0;
      while (sent < count) begin
         pick   = $urandom_range(99);
         closes = ($urandom_range(9) == 0);
         chunk[0] = pick_multibyte_lead();
         chunk[1] = pick_trail();
         chunk[2] = pick_trail();
         span     = lead_span(chunk[0]);
         if (pick < 35) begin
            chunk[0] = 8'($urandom_range(ejs_pkg::ASCII_LIMIT - 1));
            span = 1;
         end else if (pick < 75) begin
            // Well-formed multibyte character, already in chunk.
         end else if (pick < 85) begin
            chunk[0] = 8'($urandom_range(255));
            span = 1;
         end else if (pick < 93) begin
            cut = $urandom_range(1, span - 1);
            chunk[cut] = pick_non_trail();
            span = cut + 1;
         end else begin
            // String ends before the character is complete.
            span   = $urandom_range(1, span - 1);
            closes = 1'b1;
         end
         for (int unsigned i = 0; i < span; i++) begin
            offer_byte(chunk[i], closes && (i == span - 1), 1'b0, '0);
         end
         sent += span;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = 8'h00;
      req_final_byte = 1'b0;
      row_known      = 1'b0;
      row_beat       = '0;
      want_long_hold = 1'b0;
      tx_idle_pct    = 31;
      rx_idle_pct    = 65;
      error_count      = 0;
      bytes_accepted   = 0;
      strings_ended    = 0;
      segments_checked = 0;
      held_total       = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed table under the first idling mix: sender idles often,
      // receiver more often still.
      for (int i = 0; i < N_DIRECTED; i++) begin
         offer_byte(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].known,
                    '{ok: directed_rows[i].ok, len: directed_rows[i].len,
                      value: directed_rows[i].value, run_end: 1'b1});
      end
      send_random_text(60);
      drain_results();

      // Second mix: the receiver is now the quicker side.
      tx_idle_pct = 65;
      rx_idle_pct = 31;
      send_random_text(70);
      drain_results();

      // Final phase: no idling on either side, opened by the long hold-off
      // on the result channel, with a full pause of the sender half way.
      tx_idle_pct    = 0;
      rx_idle_pct    = 0;
      want_long_hold = 1'b1;
      send_random_text(35);
      drain_results();
      send_random_text(35);
      drain_results();

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d bytes in %0d closed strings, %0d result beats checked,",
               bytes_accepted, strings_ended, segments_checked);
      $display("under three idling mixes and a %0d-cycle output stall.", LONG_HOLD);
      if (error_count == 0 && expected_segments.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d failures, %0d results never seen", error_count,
                  expected_segments.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: eucjp_char_segmenter_core.f
hdl/ejs_pkg.sv
hdl/ejs_seg_unit.sv
hdl/ejs_out_reg.sv
hdl/eucjp_char_segmenter_core.sv
tb/sv/testbench.sv
